// ===== rtl/sda_pkg.sv =====
package sda_pkg;

    // Fixed field widths and defaults
    localparam int FRAC_BITS_DEF = 30;
    localparam int DIR_W         = 32;
    localparam int THR_W         = 40;
    localparam int CFG_IDX_W     = 1;
    localparam int Q_BITS        = 62;
    localparam int ALPHA_W       = 63;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGULAR_THR = 1'b1;

    // Threshold values after reset
    localparam logic [THR_W-1:0] PARALLEL_THR_RST = 40'd1152922;
    localparam logic [THR_W-1:0] SINGULAR_THR_RST = 40'd115292;

    typedef struct packed {
        logic                    first;
        logic                    last;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } sda_in_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] avg_x;
        logic signed [DIR_W-1:0] avg_y;
        logic signed [DIR_W-1:0] avg_z;
        logic                    failed;
    } sda_out_t;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_ACC_SUB,
        OP_ACC_LOAD_HI,
        OP_WB_C,
        OP_WB_LEN,
        OP_WB_NUM,
        OP_WB_V,
        OP_WB_NV,
        OP_MIDPOINT,
        OP_SET_FAIL,
        OP_DIV_START,
        OP_ALPHA,
        OP_COMMIT,
        OP_EMIT
    } dp_op_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        SEL_AD,
        SEL_CC,
        SEL_DAD,
        SEL_AC,
        SEL_VAH,
        SEL_VAL
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_LEN,
        ST_TEST,
        ST_NUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ALPHA,
        ST_CORR,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        mul_sel_t   sel;
        logic [1:0] ia;
        logic [1:0] ib;
    } dp_cmd_t;

    typedef struct packed {
        logic len_le_par;
        logic len_le_sing;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // Cyclic successors of a vector component index
    function automatic logic [1:0] comp_next1(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] comp_next2(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sda_div.sv =====
module sda_div
    import sda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NUM_W     = 67,
    parameter int LEN_W     = 69
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num_mag,
    input  logic [LEN_W-1:0]   den,
    output logic               done,
    output logic               sat,
    output logic [Q_BITS-1:0]  quot
);

    localparam int HI_W  = NUM_W - (61 - FRAC_BITS);
    localparam int CNT_W = $clog2(Q_BITS);

    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [Q_BITS-1:0] bits_reg, bits_next;
    logic [Q_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;

    logic [LEN_W:0]    r2;
    logic [LEN_W:0]    diff;
    logic              ge;
    logic [HI_W-1:0]   num_hi;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign r2     = {rem_reg, bits_reg[Q_BITS-1]};
    assign diff   = r2 - {1'b0, den};
    assign ge     = (r2 >= {1'b0, den});
    assign num_hi = num_mag[NUM_W-1:61-FRAC_BITS];

    always_comb
    begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        if (start)
        begin
            // The quotient overflows 62 bits exactly when the top part reaches den.
            rem_next  = LEN_W'(num_hi);
            sat_next  = (LEN_W'(num_hi) >= den);
            bits_next = {num_mag[60-FRAC_BITS:0], {(FRAC_BITS+1){1'b0}}};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
            bits_next = {bits_reg[Q_BITS-2:0], 1'b0};
            quot_next = {quot_reg[Q_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    assign done = done_reg;
    assign sat  = sat_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/sda_dp.sv =====
module sda_dp
    import sda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    input  sda_in_t              in_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sda_out_t             out_data
);

    localparam int C_W   = 65 - FRAC_BITS;
    localparam int V_W   = 98 - 2 * FRAC_BITS;
    localparam int LEN_W = 129 - 2 * FRAC_BITS;
    localparam int NUM_W = 67;
    localparam int ACC_W = 160 - 2 * FRAC_BITS;
    localparam int A_W   = V_W;
    localparam int B_W   = C_W;
    localparam int P_W   = A_W + B_W;

    localparam logic signed [ACC_W-1:0] RND_HALF    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF_M1 = RND_HALF - ACC_W'(1);
    localparam logic signed [ACC_W:0]   S32_MAX     = (ACC_W+1)'($signed(32'h7FFFFFFF));
    localparam logic signed [ACC_W:0]   S32_MIN     = (ACC_W+1)'($signed(32'h80000000));

    // State and configuration
    logic signed [DIR_W-1:0] run_reg [3];
    logic signed [DIR_W-1:0] run_next [3];
    logic                    fail_reg, fail_next;
    logic [THR_W-1:0]        par_thr_reg, sing_thr_reg;

    // Working registers of one fold
    logic signed [DIR_W-1:0] d_reg [3];
    logic signed [DIR_W-1:0] d_next [3];
    logic signed [C_W-1:0]   c_reg [3];
    logic signed [C_W-1:0]   c_next [3];
    logic signed [DIR_W-1:0] nv_reg [3];
    logic signed [DIR_W-1:0] nv_next [3];
    logic [LEN_W-1:0]        len_reg, len_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic signed [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic signed [V_W-1:0]   v_reg, v_next;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    sda_out_t                out_data_reg, out_data_next;

    logic signed [DIR_W-1:0] run_rd, d_rd;
    logic signed [C_W-1:0]   c_rd;
    logic signed [DIR_W:0]   ad_diff;
    logic signed [A_W-1:0]   ma;
    logic signed [B_W-1:0]   mb;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rnd_sum, rnd;
    logic signed [ACC_W:0]   nv_sum;
    logic signed [DIR_W-1:0] nv_sat;
    logic signed [DIR_W:0]   mid_sum [3];
    logic [NUM_W-1:0]        num_mag;
    logic                    div_done, div_sat;
    logic [Q_BITS-1:0]       div_q;
    logic [Q_BITS:0]         q_inc;
    logic [Q_BITS-1:0]       amag;
    logic signed [ALPHA_W-1:0] alpha_pos;

    // Operand reads at the addresses the controller chooses
    assign run_rd  = run_reg[cmd.ia];
    assign d_rd    = d_reg[cmd.ib];
    assign c_rd    = c_reg[cmd.ib];
    assign ad_diff = (DIR_W+1)'(run_rd) - (DIR_W+1)'(d_rd);

    // Shared multiplier operand selection
    always_comb
    begin
        case (cmd.sel)
            SEL_AD:
            begin
                ma = A_W'(d_rd);
                mb = B_W'(run_rd);
            end
            SEL_CC:
            begin
                ma = A_W'(c_rd);
                mb = c_rd;
            end
            SEL_DAD:
            begin
                ma = A_W'(d_rd);
                mb = B_W'(ad_diff);
            end
            SEL_AC:
            begin
                ma = A_W'(c_rd);
                mb = B_W'(run_rd);
            end
            SEL_VAH:
            begin
                ma = v_reg;
                mb = B_W'($signed(alpha_reg[ALPHA_W-1:31]));
            end
            SEL_VAL:
            begin
                ma = v_reg;
                mb = B_W'($signed({1'b0, alpha_reg[30:0]}));
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Rounding half away from zero of the accumulator to the fraction width.
    assign prod_ext = ACC_W'(prod_reg);
    assign rnd_sum  = acc_reg + (acc_reg[ACC_W-1] ? RND_HALF_M1 : RND_HALF);
    assign rnd      = rnd_sum >>> FRAC_BITS;

    // New component: running value plus correction, saturated to 32 bits.
    assign nv_sum = (ACC_W+1)'(run_rd) + (ACC_W+1)'(rnd);
    always_comb
    begin
        if (nv_sum > S32_MAX)
            nv_sat = S32_MAX[DIR_W-1:0];
        else if (nv_sum < S32_MIN)
            nv_sat = S32_MIN[DIR_W-1:0];
        else
            nv_sat = nv_sum[DIR_W-1:0];
    end

    // Midpoint sums; the arithmetic shift by one gives the floor.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mid_sum[i] = (DIR_W+1)'(run_reg[i]) + (DIR_W+1)'(d_reg[i]);
        end
    end

    // Correction factor from the quotient, rounded and saturated.
    assign num_mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign q_inc     = (Q_BITS+1)'(div_q) + (Q_BITS+1)'(1);
    assign amag      = (div_sat || (&div_q)) ? '1 : q_inc[Q_BITS:1];
    assign alpha_pos = $signed({1'b0, amag});

    sda_div #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W),
        .LEN_W     (LEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == OP_DIV_START),
        .num_mag (num_mag),
        .den     (len_reg),
        .done    (div_done),
        .sat     (div_sat),
        .quot    (div_q)
    );

    // Next values for the operation of this cycle
    always_comb
    begin
        run_next       = run_reg;
        fail_next      = fail_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        nv_next        = nv_reg;
        len_next       = len_reg;
        num_next       = num_reg;
        alpha_next     = alpha_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            OP_LOAD:
            begin
                d_next[0] = in_data.dir_x;
                d_next[1] = in_data.dir_y;
                d_next[2] = in_data.dir_z;
                if (in_data.first)
                begin
                    run_next[0] = in_data.dir_x;
                    run_next[1] = in_data.dir_y;
                    run_next[2] = in_data.dir_z;
                    fail_next   = 1'b0;
                end
            end
            OP_ACC_LOAD:    acc_next = prod_ext;
            OP_ACC_ADD:     acc_next = acc_reg + prod_ext;
            OP_ACC_SUB:     acc_next = acc_reg - prod_ext;
            OP_ACC_LOAD_HI: acc_next = prod_ext <<< 31;
            OP_WB_C:        c_next[cmd.ia] = rnd[C_W-1:0];
            OP_WB_LEN:      len_next = acc_reg[LEN_W-1:0];
            OP_WB_NUM:      num_next = acc_reg[NUM_W-1:0];
            OP_WB_V:        v_next = rnd[V_W-1:0];
            OP_WB_NV:       nv_next[cmd.ia] = nv_sat;
            OP_MIDPOINT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    run_next[i] = mid_sum[i][DIR_W:1];
                end
            end
            OP_SET_FAIL:    fail_next = 1'b1;
            OP_ALPHA:       alpha_next = num_reg[NUM_W-1] ? -alpha_pos : alpha_pos;
            OP_COMMIT:      run_next = nv_reg;
            OP_EMIT:
            begin
                out_data_next.avg_x  = run_reg[0];
                out_data_next.avg_y  = run_reg[1];
                out_data_next.avg_z  = run_reg[2];
                out_data_next.failed = fail_reg;
                out_valid_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // State, thresholds and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                run_reg[i] <= '0;
            end
            fail_reg      <= 1'b0;
            par_thr_reg   <= PARALLEL_THR_RST;
            sing_thr_reg  <= SINGULAR_THR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PARALLEL_THR: par_thr_reg  <= cfg_data;
                    CFG_SINGULAR_THR: sing_thr_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        c_reg        <= c_next;
        nv_reg       <= nv_next;
        len_reg      <= len_next;
        num_reg      <= num_next;
        alpha_reg    <= alpha_next;
        v_reg        <= v_next;
        prod_reg     <= ma * mb;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign stat.len_le_par  = (len_reg <= LEN_W'(par_thr_reg));
    assign stat.len_le_sing = (len_reg <= LEN_W'(sing_thr_reg));
    assign stat.div_done    = div_done;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/sda_ctrl.sv =====
module sda_ctrl
    import sda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_first,
    input  logic     in_last,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic [3:0] step_reg, step_next;
    logic       last_reg, last_next;
    logic [1:0] cj, ck;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            step_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    assign cj = comp_next1(comp_reg);
    assign ck = comp_next2(comp_reg);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.sel    = SEL_AD;
        cmd.ia     = comp_reg;
        cmd.ib     = comp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op    = OP_LOAD;
                    last_next = in_last;
                    comp_next = '0;
                    step_next = '0;
                    if (in_first)
                        state_next = in_last ? ST_EMIT : ST_IDLE;
                    else
                        state_next = ST_CROSS;
                end
            end
            // Cross product with the running average, one component at a time.
            ST_CROSS:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        cmd.op = OP_MUL;
                        cmd.ia = cj;
                        cmd.ib = ck;
                    end
                    4'd1: cmd.op = OP_ACC_LOAD;
                    4'd2:
                    begin
                        cmd.op = OP_MUL;
                        cmd.ia = ck;
                        cmd.ib = cj;
                    end
                    4'd3: cmd.op = OP_ACC_SUB;
                    default:
                    begin
                        cmd.op    = OP_WB_C;
                        step_next = '0;
                        if (comp_reg == 2'd2)
                        begin
                            comp_next  = '0;
                            state_next = ST_LEN;
                        end
                        else
                            comp_next = comp_reg + 1'b1;
                    end
                endcase
            end
            // Squared length of the cross product.
            ST_LEN:
            begin
                cmd.sel = SEL_CC;
                case (step_reg)
                    4'd0:
                    begin
                        cmd.op    = OP_MUL;
                        step_next = 4'd1;
                    end
                    4'd1:
                    begin
                        cmd.op = (comp_reg == 2'd0) ? OP_ACC_LOAD : OP_ACC_ADD;
                        if (comp_reg == 2'd2)
                            step_next = 4'd2;
                        else
                        begin
                            step_next = '0;
                            comp_next = comp_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_WB_LEN;
                        step_next  = '0;
                        comp_next  = '0;
                        state_next = ST_TEST;
                    end
                endcase
            end
            ST_TEST:
            begin
                if (stat.len_le_par)
                begin
                    cmd.op     = OP_MIDPOINT;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else if (stat.len_le_sing)
                begin
                    cmd.op     = OP_SET_FAIL;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                    state_next = ST_NUM;
            end
            // Numerator of the correction factor.
            ST_NUM:
            begin
                cmd.sel = SEL_DAD;
                case (step_reg)
                    4'd0:
                    begin
                        cmd.op    = OP_MUL;
                        step_next = 4'd1;
                    end
                    4'd1:
                    begin
                        cmd.op = (comp_reg == 2'd0) ? OP_ACC_LOAD : OP_ACC_ADD;
                        if (comp_reg == 2'd2)
                            step_next = 4'd2;
                        else
                        begin
                            step_next = '0;
                            comp_next = comp_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_WB_NUM;
                        step_next  = '0;
                        comp_next  = '0;
                        state_next = ST_DIV_START;
                    end
                endcase
            end
            ST_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_ALPHA;
            end
            ST_ALPHA:
            begin
                cmd.op     = OP_ALPHA;
                comp_next  = '0;
                step_next  = '0;
                state_next = ST_CORR;
            end
            // Second cross product, scaled by the factor and added on.
            ST_CORR:
            begin
                cmd.sel   = SEL_AC;
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        cmd.op = OP_MUL;
                        cmd.ia = cj;
                        cmd.ib = ck;
                    end
                    4'd1: cmd.op = OP_ACC_LOAD;
                    4'd2:
                    begin
                        cmd.op = OP_MUL;
                        cmd.ia = ck;
                        cmd.ib = cj;
                    end
                    4'd3: cmd.op = OP_ACC_SUB;
                    4'd4: cmd.op = OP_WB_V;
                    4'd5:
                    begin
                        cmd.op  = OP_MUL;
                        cmd.sel = SEL_VAH;
                    end
                    4'd6: cmd.op = OP_ACC_LOAD_HI;
                    4'd7:
                    begin
                        cmd.op  = OP_MUL;
                        cmd.sel = SEL_VAL;
                    end
                    4'd8: cmd.op = OP_ACC_ADD;
                    default:
                    begin
                        cmd.op    = OP_WB_NV;
                        step_next = '0;
                        if (comp_reg == 2'd2)
                        begin
                            comp_next  = '0;
                            state_next = ST_COMMIT;
                        end
                        else
                            comp_next = comp_reg + 1'b1;
                    end
                endcase
            end
            ST_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/shell_director_averaging.sv =====
// Running average of the shell directors of one node.
// Input channel in_valid / in_ready / in_data: one beat per director, with flags
// first (load the average, clear the failure flag) and last (emit the result).
// Output channel out_valid / out_ready / out_data: one beat per node, on last,
// carrying the averaged director and the sticky failure flag.
// Configuration: cfg_we with cfg_index and cfg_data writes a threshold at once;
// write only while the block is idle.
// A first director loads the average and starts no fold. Any other director
// runs a fold: cross product, squared length and threshold test, ending in the
// midpoint or in a failure, or else in a full correction through the numerator,
// the 62-step restoring divider, the factor, the second cross product and the
// commit; the 24 products pass the single shared multiplier. One director is
// worked on at a time: the next is taken only once the fold is through.
// The output register parts the two sides: the next director is taken while a
// result waits; should a second result be ready first, the block holds it
// until the receiver takes the waiting beat.
// Reset clears the running average and the flag, and restores the thresholds.
module shell_director_averaging
    import sda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sda_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sda_out_t             out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_first (in_data.first),
        .in_last  (in_data.last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sda_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // An accepted beat is always captured by the datapath.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (cmd.op == OP_LOAD))
        else $error("input beat accepted without a load");

    // A result is only written into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> stat.out_free)
        else $error("result written over a waiting beat");

    // The output valid only rises after an emit.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.op == OP_EMIT))
        else $error("output valid raised without a result");

endmodule
